/* src/mcpu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Momentum cell position update: shared definitions
// Sizes, register indexes, pipeline record types and the iterative root and
// quotient step used by the pipeline.
// ----------------------------------------------------------------------------
package mcpu_pkg;

  localparam int unsigned MAX_CELLS = 4096;
  localparam int unsigned IDX_W     = $clog2(MAX_CELLS);
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned MOM_FRAC  = 15;
  localparam int unsigned SUM_W     = 40;
  localparam int unsigned CFG_IDX_W = 3;

  // Root and quotient are both resolved two bits per stage.
  localparam int unsigned ROOT_W      = 32;
  localparam int unsigned STEPS       = 2;
  localparam int unsigned SQ_STAGES   = ROOT_W / STEPS;
  localparam int unsigned DV_STAGES   = ROOT_W / STEPS;
  localparam int unsigned ITER_STAGES = SQ_STAGES + DV_STAGES;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAMBDA    = 3'd0,
    REG_MOMENTUM  = 3'd1,
    REG_STEP      = 3'd2,
    REG_GRAD_LIM  = 3'd3,
    REG_DISP_LIM  = 3'd4,
    REG_CORE_W    = 3'd5,
    REG_CORE_H    = 3'd6,
    REG_THRESHOLD = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic             valid;
    logic             fixed;
    logic             last;
    logic             stored;
    logic [IDX_W-1:0] idx;
  } ctl_t;

  typedef struct packed {
    ctl_t               ctl;
    logic [30:0]        px;
    logic [30:0]        py;
    logic signed [31:0] ubx;
    logic signed [31:0] uby;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               cap;
    logic [63:0]        sq_rem;
    logic [63:0]        sq_root;
    logic [63:0]        dv_x;
    logic [63:0]        dv_y;
    logic [31:0]        q_x;
    logic [31:0]        q_y;
  } iter_t;

  function automatic logic [31:0] mag32(logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // Stages below SQ_STAGES refine the square root, the rest divide both
  // numerators by the finished root.
  function automatic iter_t iter_stage(iter_t t_in, int unsigned k);
    iter_t       t;
    logic [63:0] bitv;
    logic [63:0] trial;
    int unsigned j;
    t = t_in;
    for (int unsigned s = 0; s < STEPS; s++) begin
      if (k < SQ_STAGES) begin
        j = ROOT_W - 1 - (STEPS * k + s);
        bitv = 64'd1 << (2 * j);
        trial = t.sq_root + bitv;
        if (t.sq_rem >= trial) begin
          t.sq_rem = t.sq_rem - trial;
          t.sq_root = (t.sq_root >> 1) + bitv;
        end else begin
          t.sq_root = t.sq_root >> 1;
        end
      end else begin
        j = ROOT_W - 1 - (STEPS * (k - SQ_STAGES) + s);
        trial = {32'd0, t.sq_root[31:0]} << j;
        if (t.dv_x >= trial) begin
          t.dv_x = t.dv_x - trial;
          t.q_x = {t.q_x[30:0], 1'b1};
        end else begin
          t.q_x = {t.q_x[30:0], 1'b0};
        end
        if (t.dv_y >= trial) begin
          t.dv_y = t.dv_y - trial;
          t.q_y = {t.q_y[30:0], 1'b1};
        end else begin
          t.q_y = {t.q_y[30:0], 1'b0};
        end
      end
    end
    return t;
  endfunction

endpackage

/* src/momentum_cell_position_update.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Momentum cell position update
// Pipelined momentum step for placement cells with length cap, core clamp and
// per-iteration movement total.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                         | Direction | Transfer
//  --------+---------------------------------+-----------+------------------
//  cell    | in_valid_i / in_ready_o + data  | in        | one cell per item
//  result  | out_valid_o / out_ready_i + data| out       | one result per item
//  config  | cfg_valid_i / cfg_ready_o       | in        | one register write
//
// One item enters per cycle while the input is ready, that is with no output
// stall, no sweep and no same-cell wait. The square root and the two dividers
// resolve two bits per stage over 32 stages.
// After reset the velocity memories are swept to zero, one entry per cycle,
// over all 4096 entries; no item is accepted during the sweep.
// The whole pipeline holds when the two-entry output buffer is full, so no
// item is lost or repeated. An item whose cell is still in flight waits at the
// input until the earlier update of that cell has been written back.
//
module momentum_cell_position_update (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mcpu_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [39:0]                   cfg_data_i,
  // cell items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [11:0]                   cell_index_i,
  input  logic signed [31:0]            wire_grad_x_i,
  input  logic signed [31:0]            wire_grad_y_i,
  input  logic signed [31:0]            field_grad_x_i,
  input  logic signed [31:0]            field_grad_y_i,
  input  logic [30:0]                   pos_x_i,
  input  logic [30:0]                   pos_y_i,
  input  logic [30:0]                   cell_width_i,
  input  logic [30:0]                   cell_height_i,
  input  logic                          is_fixed_i,
  input  logic                          last_cell_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [11:0]                   out_index_o,
  output logic [30:0]                   new_x_o,
  output logic [30:0]                   new_y_o,
  output logic [31:0]                   cell_movement_o,
  output logic [39:0]                   total_movement_o,
  output logic                          converged_o,
  output logic                          last_out_o
);

  localparam int unsigned GM_W  = 64 - mcpu_pkg::FRAC_BITS;      // weighted field term
  localparam int unsigned GS_W  = GM_W + 2;                      // gradient sum
  localparam int unsigned MM_W  = 48 - mcpu_pkg::MOM_FRAC;       // momentum term
  localparam int unsigned ST_W  = 55 - mcpu_pkg::FRAC_BITS;      // step term
  localparam int unsigned V_W   = ((MM_W > ST_W) ? MM_W : ST_W) + 3;
  localparam int unsigned NSTG  = mcpu_pkg::ITER_STAGES;
  localparam logic signed [31:0] VEL_MAX = 32'sh7FFF_FFFF;
  localparam logic [mcpu_pkg::IDX_W-1:0] CLR_LAST = mcpu_pkg::IDX_W'(mcpu_pkg::MAX_CELLS - 1);

  typedef struct packed {
    mcpu_pkg::ctl_t     ctl;
    logic signed [31:0] wgx, wgy, fgx, fgy;
    logic [30:0]        px, py, cw, ch;
  } stg_a_t;

  typedef struct packed {
    mcpu_pkg::ctl_t     ctl;
    logic signed [31:0] wgx, wgy;
    logic               fpos_x, fpos_y, oneg_x, oneg_y;
    logic [63:0]        fprod_x, fprod_y;
    logic [47:0]        mprod_x, mprod_y;
    logic [30:0]        px, py;
    logic signed [31:0] ubx, uby;
  } stg_b_t;

  typedef struct packed {
    mcpu_pkg::ctl_t     ctl;
    logic signed [31:0] gx, gy;
    logic               oneg_x, oneg_y;
    logic [MM_W-1:0]    mm_x, mm_y;
    logic [30:0]        px, py;
    logic signed [31:0] ubx, uby;
  } stg_c_t;

  typedef struct packed {
    mcpu_pkg::ctl_t     ctl;
    logic               gneg_x, gneg_y, oneg_x, oneg_y;
    logic [54:0]        gs_x, gs_y;
    logic [MM_W-1:0]    mm_x, mm_y;
    logic [30:0]        px, py;
    logic signed [31:0] ubx, uby;
  } stg_d_t;

  typedef struct packed {
    mcpu_pkg::ctl_t     ctl;
    logic signed [31:0] vx, vy;
    logic [30:0]        ax, ay;
    logic [30:0]        px, py;
    logic signed [31:0] ubx, uby;
  } stg_e_t;

  typedef struct packed {
    mcpu_pkg::ctl_t     ctl;
    logic signed [31:0] vx, vy;
    logic [61:0]        sq_x, sq_y, nm_x, nm_y, lim2;
    logic [30:0]        px, py;
    logic signed [31:0] ubx, uby;
  } stg_f_t;

  typedef struct packed {
    logic [11:0] idx;
    logic [30:0] nx, ny;
    logic [31:0] move;
    logic [39:0] total;
    logic        conv;
    logic        last;
  } res_t;

  // Configuration registers
  logic [31:0] lambda_q;
  logic [15:0] momentum_q;
  logic [23:0] step_q;
  logic [30:0] grad_lim_q, disp_lim_q, core_w_q, core_h_q;
  logic [39:0] threshold_q;

  // Pipeline
  stg_a_t a_q;
  stg_b_t b_q;
  stg_c_t c_q;
  stg_d_t d_q;
  stg_e_t e_q;
  stg_f_t f_q;
  mcpu_pkg::iter_t iter_in;
  mcpu_pkg::iter_t iter_d [NSTG];
  mcpu_pkg::iter_t iter_q [NSTG];
  mcpu_pkg::iter_t fin;

  logic signed [31:0] rdx_q, rdy_q;
  logic signed [31:0] vel_x_mem [mcpu_pkg::MAX_CELLS];
  logic signed [31:0] vel_y_mem [mcpu_pkg::MAX_CELLS];

  logic                       clr_busy_q;
  logic [mcpu_pkg::IDX_W-1:0] clr_addr_q;
  logic [39:0]                sum_q, sum_d;

  logic adv, accept, hazard;
  logic wr_en;
  logic [mcpu_pkg::IDX_W-1:0] wr_addr;
  logic signed [31:0] wr_vx, wr_vy;
  res_t res;

  res_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  // The pipeline moves as a whole unless the output buffer is full.
  assign adv         = (cnt_q != 2'd2);
  assign in_ready_o  = adv && !clr_busy_q && !hazard;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lambda_q    <= 32'd65536;
      momentum_q  <= 16'd29491;
      step_q      <= 24'd65536;
      grad_lim_q  <= 31'd65536;
      disp_lim_q  <= 31'd65536;
      core_w_q    <= 31'd67108864;
      core_h_q    <= 31'd67108864;
      threshold_q <= 40'd65536;
    end else if (cfg_valid_i) begin
      unique case (mcpu_pkg::cfg_reg_e'(cfg_index_i))
        mcpu_pkg::REG_LAMBDA:    lambda_q    <= cfg_data_i[31:0];
        mcpu_pkg::REG_MOMENTUM:  momentum_q  <= cfg_data_i[15:0];
        mcpu_pkg::REG_STEP:      step_q      <= cfg_data_i[23:0];
        mcpu_pkg::REG_GRAD_LIM:  grad_lim_q  <= cfg_data_i[30:0];
        mcpu_pkg::REG_DISP_LIM:  disp_lim_q  <= cfg_data_i[30:0];
        mcpu_pkg::REG_CORE_W:    core_w_q    <= cfg_data_i[30:0];
        mcpu_pkg::REG_CORE_H:    core_h_q    <= cfg_data_i[30:0];
        mcpu_pkg::REG_THRESHOLD: threshold_q <= cfg_data_i[39:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Same-cell interlock: an item waits while any earlier moving item of the
  // same cell has not yet written its velocity back.
  // --------------------------------------------------------------------------
  function automatic logic hit(mcpu_pkg::ctl_t c, logic [11:0] idx);
    return c.valid && !c.fixed && c.stored && (c.idx == idx);
  endfunction

  always_comb begin
    hazard = hit(a_q.ctl, cell_index_i) || hit(b_q.ctl, cell_index_i) ||
             hit(c_q.ctl, cell_index_i) || hit(d_q.ctl, cell_index_i) ||
             hit(e_q.ctl, cell_index_i) || hit(f_q.ctl, cell_index_i);
    for (int k = 0; k < NSTG; k++) begin
      hazard = hazard || hit(iter_q[k].ctl, cell_index_i);
    end
  end

  // --------------------------------------------------------------------------
  // Velocity memories and the clearing sweep after reset
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == CLR_LAST) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      vel_x_mem[clr_addr_q] <= '0;
      vel_y_mem[clr_addr_q] <= '0;
    end else if (wr_en) begin
      vel_x_mem[wr_addr] <= wr_vx;
      vel_y_mem[wr_addr] <= wr_vy;
    end
    if (adv) begin
      rdx_q <= vel_x_mem[cell_index_i[mcpu_pkg::IDX_W-1:0]];
      rdy_q <= vel_y_mem[cell_index_i[mcpu_pkg::IDX_W-1:0]];
    end
  end

  // --------------------------------------------------------------------------
  // Front stages: gradient, momentum, velocity, squares
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
    end else if (adv) begin
      a_q.ctl.valid  <= accept;
      a_q.ctl.fixed  <= is_fixed_i;
      a_q.ctl.last   <= last_cell_i;
      a_q.ctl.stored <= ({1'b0, cell_index_i} < 13'(mcpu_pkg::MAX_CELLS));
      a_q.ctl.idx    <= cell_index_i;
      a_q.wgx <= wire_grad_x_i;
      a_q.wgy <= wire_grad_y_i;
      a_q.fgx <= field_grad_x_i;
      a_q.fgy <= field_grad_y_i;
      a_q.px  <= pos_x_i;
      a_q.py  <= pos_y_i;
      a_q.cw  <= cell_width_i;
      a_q.ch  <= cell_height_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q <= '0;
    end else if (adv) begin
      b_q.ctl     <= a_q.ctl;
      b_q.wgx     <= a_q.wgx;
      b_q.wgy     <= a_q.wgy;
      b_q.fpos_x  <= !a_q.fgx[31] && (a_q.fgx != 0);
      b_q.fpos_y  <= !a_q.fgy[31] && (a_q.fgy != 0);
      b_q.fprod_x <= 64'(mcpu_pkg::mag32(a_q.fgx)) * 64'(lambda_q);
      b_q.fprod_y <= 64'(mcpu_pkg::mag32(a_q.fgy)) * 64'(lambda_q);
      // an index beyond the store reads as zero velocity
      b_q.oneg_x  <= a_q.ctl.stored && rdx_q[31];
      b_q.oneg_y  <= a_q.ctl.stored && rdy_q[31];
      b_q.mprod_x <= a_q.ctl.stored ? 48'(mcpu_pkg::mag32(rdx_q)) * 48'(momentum_q) : '0;
      b_q.mprod_y <= a_q.ctl.stored ? 48'(mcpu_pkg::mag32(rdy_q)) * 48'(momentum_q) : '0;
      b_q.px      <= a_q.px;
      b_q.py      <= a_q.py;
      b_q.ubx     <= $signed({1'b0, core_w_q}) - $signed({1'b0, a_q.cw});
      b_q.uby     <= $signed({1'b0, core_h_q}) - $signed({1'b0, a_q.ch});
    end
  end

  // Density term is the negated field gradient, then each component is clipped.
  function automatic logic signed [31:0] grad_clip(logic signed [31:0] wg, logic fpos,
                                                   logic [63:0] fprod, logic [30:0] lim);
    logic signed [GS_W-1:0] gm;
    logic signed [GS_W-1:0] sum;
    logic signed [GS_W-1:0] limw;
    gm   = GS_W'(fprod >> mcpu_pkg::FRAC_BITS);
    sum  = fpos ? GS_W'(wg) - gm : GS_W'(wg) + gm;
    limw = GS_W'({1'b0, lim});
    if (sum > limw) begin
      sum = limw;
    end
    if (sum < -limw) begin
      sum = -limw;
    end
    return 32'(sum);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
    end else if (adv) begin
      c_q.ctl    <= b_q.ctl;
      c_q.gx     <= grad_clip(b_q.wgx, b_q.fpos_x, b_q.fprod_x, grad_lim_q);
      c_q.gy     <= grad_clip(b_q.wgy, b_q.fpos_y, b_q.fprod_y, grad_lim_q);
      c_q.oneg_x <= b_q.oneg_x;
      c_q.oneg_y <= b_q.oneg_y;
      c_q.mm_x   <= MM_W'(b_q.mprod_x >> mcpu_pkg::MOM_FRAC);
      c_q.mm_y   <= MM_W'(b_q.mprod_y >> mcpu_pkg::MOM_FRAC);
      c_q.px     <= b_q.px;
      c_q.py     <= b_q.py;
      c_q.ubx    <= b_q.ubx;
      c_q.uby    <= b_q.uby;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_q <= '0;
    end else if (adv) begin
      d_q.ctl    <= c_q.ctl;
      d_q.gneg_x <= c_q.gx[31];
      d_q.gneg_y <= c_q.gy[31];
      d_q.gs_x   <= 55'(31'(mcpu_pkg::mag32(c_q.gx))) * 55'(step_q);
      d_q.gs_y   <= 55'(31'(mcpu_pkg::mag32(c_q.gy))) * 55'(step_q);
      d_q.oneg_x <= c_q.oneg_x;
      d_q.oneg_y <= c_q.oneg_y;
      d_q.mm_x   <= c_q.mm_x;
      d_q.mm_y   <= c_q.mm_y;
      d_q.px     <= c_q.px;
      d_q.py     <= c_q.py;
      d_q.ubx    <= c_q.ubx;
      d_q.uby    <= c_q.uby;
    end
  end

  // v = momentum * v_old - step * g, saturated to +/-(2^31 - 1).
  function automatic logic signed [31:0] vel_new(logic oneg, logic [MM_W-1:0] mm,
                                                 logic gneg, logic [54:0] gs);
    logic signed [V_W-1:0] mt;
    logic signed [V_W-1:0] gt;
    logic signed [V_W-1:0] v;
    mt = oneg ? -V_W'(mm) : V_W'(mm);
    gt = gneg ? -V_W'(ST_W'(gs >> mcpu_pkg::FRAC_BITS)) : V_W'(ST_W'(gs >> mcpu_pkg::FRAC_BITS));
    v  = mt - gt;
    if (v > V_W'(VEL_MAX)) begin
      v = V_W'(VEL_MAX);
    end
    if (v < -V_W'(VEL_MAX)) begin
      v = -V_W'(VEL_MAX);
    end
    return 32'(v);
  endfunction

  logic signed [31:0] e_vx, e_vy;
  assign e_vx = vel_new(d_q.oneg_x, d_q.mm_x, d_q.gneg_x, d_q.gs_x);
  assign e_vy = vel_new(d_q.oneg_y, d_q.mm_y, d_q.gneg_y, d_q.gs_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_q <= '0;
    end else if (adv) begin
      e_q.ctl <= d_q.ctl;
      e_q.vx  <= e_vx;
      e_q.vy  <= e_vy;
      e_q.ax  <= 31'(mcpu_pkg::mag32(e_vx));
      e_q.ay  <= 31'(mcpu_pkg::mag32(e_vy));
      e_q.px  <= d_q.px;
      e_q.py  <= d_q.py;
      e_q.ubx <= d_q.ubx;
      e_q.uby <= d_q.uby;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_q <= '0;
    end else if (adv) begin
      f_q.ctl  <= e_q.ctl;
      f_q.vx   <= e_q.vx;
      f_q.vy   <= e_q.vy;
      f_q.sq_x <= 62'(e_q.ax) * 62'(e_q.ax);
      f_q.sq_y <= 62'(e_q.ay) * 62'(e_q.ay);
      f_q.nm_x <= 62'(e_q.ax) * 62'(disp_lim_q);
      f_q.nm_y <= 62'(e_q.ay) * 62'(disp_lim_q);
      f_q.lim2 <= 62'(disp_lim_q) * 62'(disp_lim_q);
      f_q.px   <= e_q.px;
      f_q.py   <= e_q.py;
      f_q.ubx  <= e_q.ubx;
      f_q.uby  <= e_q.uby;
    end
  end

  // --------------------------------------------------------------------------
  // Length cap: square root of vx^2 + vy^2, then both scaled components
  // --------------------------------------------------------------------------
  logic [63:0] len2;
  assign len2 = 64'(f_q.sq_x) + 64'(f_q.sq_y);

  always_comb begin
    iter_in         = '0;
    iter_in.ctl     = f_q.ctl;
    iter_in.px      = f_q.px;
    iter_in.py      = f_q.py;
    iter_in.ubx     = f_q.ubx;
    iter_in.uby     = f_q.uby;
    iter_in.vx      = f_q.vx;
    iter_in.vy      = f_q.vy;
    iter_in.cap     = len2 > 64'(f_q.lim2);
    iter_in.sq_rem  = len2;
    iter_in.dv_x    = 64'(f_q.nm_x);
    iter_in.dv_y    = 64'(f_q.nm_y);
  end

  for (genvar k = 0; k < NSTG; k++) begin : g_iter
    if (k == 0) begin : g_first
      assign iter_d[k] = mcpu_pkg::iter_stage(iter_in, k);
    end else begin : g_next
      assign iter_d[k] = mcpu_pkg::iter_stage(iter_q[k-1], k);
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        iter_q[k] <= '0;
      end else if (adv) begin
        iter_q[k] <= iter_d[k];
      end
    end
  end

  assign fin = iter_q[NSTG-1];

  // --------------------------------------------------------------------------
  // Final velocity, write-back, clamp and movement total
  // --------------------------------------------------------------------------
  logic signed [31:0] fvx, fvy;
  logic [30:0]        fax, fay;
  logic signed [32:0] nx, ny;
  logic [31:0]        move;
  logic [40:0]        sum_add;
  logic [39:0]        sum_new;

  always_comb begin
    fvx = fin.cap ? (fin.vx[31] ? -$signed({1'b0, fin.q_x[30:0]}) : $signed({1'b0, fin.q_x[30:0]}))
                  : fin.vx;
    fvy = fin.cap ? (fin.vy[31] ? -$signed({1'b0, fin.q_y[30:0]}) : $signed({1'b0, fin.q_y[30:0]}))
                  : fin.vy;
    fax = fin.cap ? fin.q_x[30:0] : 31'(mcpu_pkg::mag32(fin.vx));
    fay = fin.cap ? fin.q_y[30:0] : 31'(mcpu_pkg::mag32(fin.vy));

    nx = $signed({2'b00, fin.px}) + 33'(fvx);
    ny = $signed({2'b00, fin.py}) + 33'(fvy);
    if (nx > 33'(fin.ubx)) begin
      nx = 33'(fin.ubx);
    end
    if (ny > 33'(fin.uby)) begin
      ny = 33'(fin.uby);
    end
    if (nx < 0) begin
      nx = '0;
    end
    if (ny < 0) begin
      ny = '0;
    end

    move    = fin.ctl.fixed ? '0 : 32'(fax) + 32'(fay);
    sum_add = 41'(sum_q) + 41'(move);
    sum_new = sum_add[40] ? '1 : sum_add[39:0];
    sum_d   = fin.ctl.last ? '0 : sum_new;

    res.idx   = fin.ctl.idx;
    res.nx    = fin.ctl.fixed ? fin.px : nx[30:0];
    res.ny    = fin.ctl.fixed ? fin.py : ny[30:0];
    res.move  = move;
    res.total = fin.ctl.last ? sum_new : '0;
    res.conv  = fin.ctl.last && (sum_new < threshold_q);
    res.last  = fin.ctl.last;

    wr_en   = adv && fin.ctl.valid && !fin.ctl.fixed && fin.ctl.stored;
    wr_addr = fin.ctl.idx[mcpu_pkg::IDX_W-1:0];
    wr_vx   = fvx;
    wr_vy   = fvy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (adv && fin.ctl.valid) begin
      sum_q <= sum_d;
    end
  end

  // --------------------------------------------------------------------------
  // Two-entry output buffer
  // --------------------------------------------------------------------------
  assign push = adv && fin.ctl.valid;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  assign out_valid_o      = (cnt_q != 2'd0);
  assign out_index_o      = fifo_q[rd_ptr_q].idx;
  assign new_x_o          = fifo_q[rd_ptr_q].nx;
  assign new_y_o          = fifo_q[rd_ptr_q].ny;
  assign cell_movement_o  = fifo_q[rd_ptr_q].move;
  assign total_movement_o = fifo_q[rd_ptr_q].total;
  assign converged_o      = fifo_q[rd_ptr_q].conv;
  assign last_out_o       = fifo_q[rd_ptr_q].last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_raw_collision : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !(wr_en && (wr_addr == cell_index_i[mcpu_pkg::IDX_W-1:0])))
    else $error("velocity write-back collides with an entering item of the same cell");

  a_buffer_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer count out of range");

  a_total_only_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_out_o) |-> (!converged_o && (total_movement_o == 40'd0)))
    else $error("total or converged flag set on a result that is not the last");

  a_no_accept_in_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |=> !a_q.ctl.valid || !$past(clr_busy_q))
    else $error("item entered the pipeline during the clearing sweep");

endmodule
